[hdl/cqr_pkg.sv]
// Shared constants and types for the circular queue with replay.
package cqr_pkg;

	localparam int DEPTH      = 8;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = 4;
	localparam int REP_W      = 4;
	localparam int PASS_W     = 3;
	localparam int ENTRY_W    = 16;
	localparam int MAX_REPEAT = 8;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_PLAY   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_EXEC
	} state_t;

endpackage

[hdl/circular_queue_with_replay_top.sv]
// Circular queue of entry words with add, remove, replay and clear.
//
// Input channel: in_valid / in_stall carry op, entry_data and repeat_count.
// An item is taken at a rising edge with in_valid high and in_stall low.
// in_stall is high from acceptance until the last result of the item has
// been loaded into the output register.
// Output channel: out_valid / out_stall carry status, entry_out,
// pass_number, position, fill_after and last. A result is taken at an edge
// with out_valid high and out_stall low; last marks the final result of
// the item. The output register holds while out_stall is high, and the
// queue takes the next item while a finished result still waits there.
// Sequence: the index unit and the registered store read serve one walk
// step at a time. Add, remove and clear pass through accept, store read
// and execute; play repeats store read and execute for each result, so a
// play of n entries over p passes emits n*p results.
// A play of zero passes on a non-empty queue ends with no result.
// A result waiting on a stalled receiver holds the next one back.
// Reset (arst_n low, asynchronous): queue empty, capacity 8, head 0,
// tail capacity minus one, no result pending. The store needs no clearing.
// Configuration: cfg_wr_en with cfg_wr_data sets the capacity in use; it
// is taken only while the queue is empty (0 reads as 1, above 8 as 8).
module circular_queue_with_replay_top
	import cqr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CNT_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [ENTRY_W-1:0] entry_data,
	input  logic [REP_W-1:0]   repeat_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [ENTRY_W-1:0] entry_out,
	output logic [PASS_W-1:0]  pass_number,
	output logic [IDX_W-1:0]   position,
	output logic [CNT_W-1:0]   fill_after,
	output logic               last
);

	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
	localparam logic [REP_W-1:0] MAX_REP_C = REP_W'(MAX_REPEAT);

	// Queue state
	state_t              state_q, state_d;
	logic [IDX_W-1:0]    head_q, head_d;
	logic [IDX_W-1:0]    tail_q, tail_d;
	logic [CNT_W-1:0]    fill_q, fill_d;
	logic [CNT_W-1:0]    cap_q, cap_d;

	// Item being worked on
	op_t                 op_q;
	logic [ENTRY_W-1:0]  data_q;
	logic [REP_W-1:0]    reps_q;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic [PASS_W-1:0]   pass_q, pass_d;
	logic [IDX_W-1:0]    pos_q, pos_d;

	// Entry store with registered read
	logic [ENTRY_W-1:0]  mem [DEPTH];
	logic [ENTRY_W-1:0]  rd_data_q;
	logic                mem_we;

	// Output register
	logic                out_valid_q;
	status_t             status_q, status_d;
	logic [ENTRY_W-1:0]  entry_out_q, entry_d;
	logic [PASS_W-1:0]   pass_out_q, pass_out_d;
	logic [IDX_W-1:0]    pos_out_q, pos_out_d;
	logic [CNT_W-1:0]    fill_out_q;
	logic                last_q, last_d;
	logic                load;

	// Shared index unit: next index with wrap at the capacity in use
	logic [IDX_W-1:0]    wrap_in;
	logic [CNT_W-1:0]    wrap_sum;
	logic [IDX_W-1:0]    wrap_out;

	logic                accept;
	logic                out_free;
	logic                pos_end;
	logic                play_last;
	logic [CNT_W-1:0]    cap_new;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Add advances the tail; remove and play walk from idx_q
	assign wrap_in  = (op_q == OP_ADD) ? tail_q : idx_q;
	assign wrap_sum = CNT_W'(wrap_in) + CNT_W'(1);
	assign wrap_out = (wrap_sum >= cap_q) ? '0 : wrap_sum[IDX_W-1:0];

	// End of one pass, and end of the whole replay
	assign pos_end   = (CNT_W'(pos_q) + CNT_W'(1)) == fill_q;
	assign play_last = pos_end && ((REP_W'(pass_q) + REP_W'(1)) == reps_q);

	// Clamp a capacity write into 1..DEPTH
	always_comb begin
		if (cfg_wr_data == '0) begin
			cap_new = CNT_W'(1);
		end else if (cfg_wr_data > DEPTH_C) begin
			cap_new = DEPTH_C;
		end else begin
			cap_new = cfg_wr_data;
		end
	end

	// Sequencer: next state, queue update and result assembly
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		fill_d     = fill_q;
		cap_d      = cap_q;
		idx_d      = idx_q;
		pass_d     = pass_q;
		pos_d      = pos_q;
		mem_we     = 1'b0;
		load       = 1'b0;
		status_d   = ST_OK;
		entry_d    = '0;
		pass_out_d = '0;
		pos_out_d  = '0;
		last_d     = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					// Start every walk at the oldest entry
					idx_d   = head_q;
					pass_d  = '0;
					pos_d   = '0;
					state_d = S_RD;
				end
			end
			S_RD: begin
				// Store read at idx_q lands in rd_data_q
				state_d = S_EXEC;
			end
			S_EXEC: begin
				case (op_q)
					OP_ADD: begin
						if (out_free) begin
							load    = 1'b1;
							state_d = S_IDLE;
							if (fill_q >= cap_q) begin
								status_d = ST_FULL;
							end else begin
								mem_we = 1'b1;
								tail_d = wrap_out;
								fill_d = fill_q + CNT_W'(1);
							end
						end
					end
					OP_REMOVE: begin
						if (out_free) begin
							load    = 1'b1;
							state_d = S_IDLE;
							if (fill_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								entry_d = rd_data_q;
								head_d  = wrap_out;
								fill_d  = fill_q - CNT_W'(1);
							end
						end
					end
					OP_PLAY: begin
						if (fill_q == '0) begin
							if (out_free) begin
								load     = 1'b1;
								status_d = ST_EMPTY;
								state_d  = S_IDLE;
							end
						end else if (reps_q == '0) begin
							// Drop the item: nothing to replay
							state_d = S_IDLE;
						end else if (out_free) begin
							load       = 1'b1;
							entry_d    = rd_data_q;
							pass_out_d = pass_q;
							pos_out_d  = pos_q;
							last_d     = play_last;
							if (play_last) begin
								state_d = S_IDLE;
							end else begin
								state_d = S_RD;
								if (pos_end) begin
									idx_d  = head_q;
									pos_d  = '0;
									pass_d = pass_q + PASS_W'(1);
								end else begin
									idx_d = wrap_out;
									pos_d = pos_q + IDX_W'(1);
								end
							end
						end
					end
					OP_CLEAR: begin
						if (out_free) begin
							load    = 1'b1;
							state_d = S_IDLE;
							head_d  = '0;
							tail_d  = IDX_W'(cap_q - CNT_W'(1));
							fill_d  = '0;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Capacity write, taken only on an empty queue
		if (cfg_wr_en && (fill_q == '0)) begin
			cap_d  = cap_new;
			head_d = '0;
			tail_d = IDX_W'(cap_new - CNT_W'(1));
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= IDX_W'(DEPTH - 1);
			fill_q      <= '0;
			cap_q       <= DEPTH_C;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			fill_q  <= fill_d;
			cap_q   <= cap_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(op);
			data_q <= entry_data;
			reps_q <= (repeat_count > MAX_REP_C) ? MAX_REP_C : repeat_count;
		end
		idx_q  <= idx_d;
		pass_q <= pass_d;
		pos_q  <= pos_d;
	end

	// Entry store: write at the new tail, read at the walk index
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wrap_out] <= data_q;
		end
		rd_data_q <= mem[idx_q];
	end

	// Output payload: hold while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			status_q    <= status_d;
			entry_out_q <= entry_d;
			pass_out_q  <= pass_out_d;
			pos_out_q   <= pos_out_d;
			fill_out_q  <= fill_d;
			last_q      <= last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_out   = entry_out_q;
	assign pass_number = pass_out_q;
	assign position    = pos_out_q;
	assign fill_after  = fill_out_q;
	assign last        = last_q;

endmodule
